// ===== sv/rsbb_pkg.sv =====
`default_nettype none

package rsbb_pkg;

  // Pixel layout: red in the top byte, blue in the bottom byte.
  localparam int CH_W      = 8;
  localparam int NUM_LANES = 3;
  localparam int PIX_W     = NUM_LANES * CH_W;

  localparam int RADIUS_W = 5;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1);

  localparam int DEF_MAX_RADIUS = 31;
  localparam int DEF_MAX_LINE   = 4096;

  // One window tap, sent to every color lane together with the ring read data.
  typedef struct packed {
    logic valid;
    logic clear;
    logic sub;
    logic use_first;
  } tap_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FULL,
    ST_INC_ADD,
    ST_INC_SUB,
    ST_SETTLE,
    ST_MUL,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== sv/rsbb_if.sv =====
`default_nettype none

interface rsbb_pix_if;
  import rsbb_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;
  logic            end_of_line;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output end_of_line, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  input end_of_line, output ready);
endinterface

interface rsbb_res_if;
  import rsbb_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic            line_done;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output line_done, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input line_done, output ready);
endinterface

interface rsbb_cfg_if;
  import rsbb_pkg::*;
  logic                valid;
  logic                ready;
  logic [RADIUS_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/rsbb_ram.sv =====
`default_nettype none

module rsbb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/rsbb_lane.sv =====
`default_nettype none

module rsbb_lane #(
  parameter int SUM_W   = 14,
  parameter int RECIP_W = 21
) (
  input  logic                      clk,
  input  rsbb_pkg::tap_t            tap,
  input  logic [rsbb_pkg::CH_W-1:0] ram_sample,
  input  logic [rsbb_pkg::CH_W-1:0] first_sample,
  input  logic                      mul_en,
  input  logic [RECIP_W-1:0]        recip,
  output logic [rsbb_pkg::CH_W-1:0] quotient
);
  import rsbb_pkg::*;

  localparam int SHIFT  = RECIP_W - 1;
  localparam int PROD_W = SUM_W + RECIP_W;

  logic [SUM_W-1:0]  acc;
  logic [SUM_W-1:0]  sample;
  logic [PROD_W-1:0] prod;

  assign sample = SUM_W'(tap.use_first ? first_sample : ram_sample);

  // The window sum is kept modulo 2^SUM_W, so a subtract never goes wrong
  // even when it briefly passes below zero.
  always_ff @(posedge clk) begin
    if (tap.valid) begin
      if (tap.clear) begin
        acc <= sample;
      end else if (tap.sub) begin
        acc <= acc - sample;
      end else begin
        acc <= acc + sample;
      end
    end
    if (mul_en) begin
      prod <= PROD_W'(acc) * PROD_W'(recip);
    end
  end

  // The reciprocal carries enough fraction bits that the truncated product is
  // the exact floor of the quotient for every window sum.
  assign quotient = prod[SHIFT +: CH_W];

endmodule

`default_nettype wire

// ===== sv/rsbb_merge.sv =====
`default_nettype none

module rsbb_merge (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic [rsbb_pkg::CH_W-1:0] red,
  input  logic [rsbb_pkg::CH_W-1:0] green,
  input  logic [rsbb_pkg::CH_W-1:0] blue,
  input  logic                      done,
  output logic                      space,
  rsbb_res_if.source                results
);
  import rsbb_pkg::*;

  logic            out_valid;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic            out_done;

  assign space = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_red   <= red;
      out_green <= green;
      out_blue  <= blue;
      out_done  <= done;
    end
  end

  assign results.valid     = out_valid;
  assign results.red_out   = out_red;
  assign results.green_out = out_green;
  assign results.blue_out  = out_blue;
  assign results.line_done = out_done;

endmodule

`default_nettype wire

// ===== sv/running_sum_box_blur_line.sv =====
`default_nettype none

// Clamp-to-edge box filter for one line of RGB pixels. Each pixel request
// enters with an end-of-line flag; each result request carries the per-color
// floor mean of the 2r+1 pixels centered on one line position, where r is the
// radius register (saturated at MAX_RADIUS) and pixels beyond either end of the
// line repeat the end pixel. The result for position j leaves once pixel j+r
// has arrived, and all pending positions flush when the line ends; line_done
// marks the last one. A new pixel is taken only after the previous one's
// results are all computed: each pixel takes an accept and a final check,
// plus for each result it releases a check, the tap reads, a settle, a
// multiply and an emit that waits for output room. The tap reads are two
// when the running sums can be updated (one ring read to add the entering
// pixel, one to remove the leaving one) or 2r+1 when the window is summed
// from scratch (the first result of a line, or the first after a radius
// change). The pace is set by the single read port of the pixel ring, which
// feeds one window tap a cycle to all three color lanes. A finished result
// may wait in the output register while the next pixel is accepted. No
// clearing pass after reset is needed; the radius is 1 after reset.
module running_sum_box_blur_line #(
  parameter int MAX_RADIUS = rsbb_pkg::DEF_MAX_RADIUS,
  parameter int MAX_LINE   = rsbb_pkg::DEF_MAX_LINE
) (
  input  logic       clk,
  input  logic       rst,
  rsbb_cfg_if.sink   cfg,
  rsbb_pix_if.sink   pixels,
  rsbb_res_if.source results
);
  import rsbb_pkg::*;

  // Radius width, ring depth (must hold 2r+2 pixels) and position width.
  localparam int RW         = $clog2(MAX_RADIUS + 1);
  localparam int RING_AW    = RW + 1;
  localparam int RING_DEPTH = 1 << RING_AW;
  localparam int POSW       = $clog2(MAX_LINE);
  localparam int KW         = POSW + RW + 2;
  // Window sums, and the reciprocal that makes the divide exact.
  localparam int SUM_W      = $clog2((2 * MAX_RADIUS + 1) * 255 + 1);
  localparam int DIV_W      = RW + 1;
  localparam int SHIFT      = SUM_W + DIV_W;
  localparam int RECIP_W    = SHIFT + 1;

  state_t state, state_next;

  logic [RADIUS_W-1:0] radius;
  logic [RW-1:0]       r_eff;
  logic [RW-1:0]       r_cur;
  logic [RW-1:0]       sum_r;

  logic [POSW-1:0] in_pos;
  logic [POSW-1:0] cur_i;
  logic [POSW:0]   out_pos;
  logic            last_f;
  logic [PIX_W-1:0] first_pix;
  logic [PIX_W-1:0] pix_word;
  logic [PIX_W-1:0] ram_rdata;

  logic [RECIP_W-1:0] recip_tab [MAX_RADIUS + 1];
  logic [RECIP_W-1:0] recip;

  logic signed [KW-1:0] k, k_sel, k_clamp;
  logic signed [KW-1:0] j_s, i_s, r_s, win_lo, win_hi;

  tap_t tap_issue, tap_q;

  logic pix_acc;
  logic in_last;
  logic done_cond;
  logic inc_ok;
  logic mul_en;
  logic emit_load;
  logic space;
  logic line_end_pos;

  logic [CH_W-1:0] lane_q [NUM_LANES];

  // Reciprocal table: ceil(2^SHIFT / (2r+1)) for every radius.
  for (genvar g = 0; g <= MAX_RADIUS; g++) begin : g_recip
    localparam int unsigned RECIP_VAL = ((1 << SHIFT) + 2 * g) / (2 * g + 1);
    assign recip_tab[g] = RECIP_W'(RECIP_VAL);
  end

  // Configuration: the radius register takes any write.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg.valid) begin
      radius <= cfg.data;
    end
  end

  assign r_eff = (int'(radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius);

  // Input side.
  assign pixels.ready = (state == ST_IDLE);
  assign pix_acc      = pixels.valid && pixels.ready;
  assign pix_word     = {pixels.red_in, pixels.green_in, pixels.blue_in};
  // An overlong line is cut at the last position the counters can hold.
  assign in_last      = pixels.end_of_line || (in_pos >= POSW'(MAX_LINE - 1));

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      cur_i  <= in_pos;
      last_f <= in_last;
      r_cur  <= r_eff;
      recip  <= recip_tab[r_eff];
      if (in_pos == '0) begin
        first_pix <= pix_word;
      end
    end
  end

  // Window bounds of the next output position.
  assign j_s    = KW'(out_pos);
  assign i_s    = KW'(cur_i);
  assign r_s    = KW'(r_cur);
  assign win_lo = j_s - r_s;
  assign win_hi = j_s + r_s;

  // Nothing more to release: every position is out, or the next one still
  // waits for pixel j+r.
  assign done_cond    = (j_s > i_s) || (!last_f && (win_hi > i_s));
  // The running sums hold the window of position j-1 at the same radius.
  assign inc_ok       = (out_pos != '0) && (sum_r == r_cur);
  assign line_end_pos = last_f && (j_s == i_s);

  always_comb begin
    state_next = state;
    tap_issue  = '0;
    k_sel      = k;
    mul_en     = 1'b0;
    emit_load  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (pix_acc) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (done_cond) begin
          state_next = ST_IDLE;
        end else if (inc_ok) begin
          state_next = ST_INC_ADD;
        end else begin
          state_next = ST_FULL;
        end
      end
      ST_FULL: begin
        tap_issue.valid     = 1'b1;
        tap_issue.clear     = (k == win_lo);
        tap_issue.use_first = k_sel[KW-1];
        if (k == win_hi) begin
          state_next = ST_SETTLE;
        end
      end
      ST_INC_ADD: begin
        k_sel               = win_hi;
        tap_issue.valid     = 1'b1;
        tap_issue.use_first = k_sel[KW-1];
        state_next          = ST_INC_SUB;
      end
      ST_INC_SUB: begin
        k_sel               = win_lo - KW'(1);
        tap_issue.valid     = 1'b1;
        tap_issue.sub       = 1'b1;
        tap_issue.use_first = k_sel[KW-1];
        state_next          = ST_SETTLE;
      end
      ST_SETTLE: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        mul_en     = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (space) begin
          emit_load  = 1'b1;
          state_next = ST_CHECK;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Taps past the newest pixel repeat it; taps before the line start use the
  // held first pixel and ignore the ring data.
  assign k_clamp = (k_sel > i_s) ? i_s : k_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      in_pos  <= '0;
      out_pos <= '0;
      tap_q   <= '0;
    end else begin
      state <= state_next;
      tap_q <= tap_issue;
      if (state == ST_CHECK && done_cond) begin
        if (last_f) begin
          in_pos  <= '0;
          out_pos <= '0;
        end else begin
          in_pos <= cur_i + POSW'(1);
        end
      end
      if (emit_load) begin
        out_pos <= out_pos + (POSW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CHECK) begin
      k <= win_lo;
    end else if (state == ST_FULL) begin
      k <= k + KW'(1);
    end
    if (emit_load) begin
      sum_r <= r_cur;
    end
  end

  rsbb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (pix_acc),
    .waddr (RING_AW'(in_pos)),
    .wdata (pix_word),
    .re    (tap_issue.valid),
    .raddr (RING_AW'(k_clamp)),
    .rdata (ram_rdata)
  );

  // One lane per color, red first.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    rsbb_lane #(
      .SUM_W   (SUM_W),
      .RECIP_W (RECIP_W)
    ) u_lane (
      .clk          (clk),
      .tap          (tap_q),
      .ram_sample   (ram_rdata[PIX_W - CH_W * (g + 1) +: CH_W]),
      .first_sample (first_pix[PIX_W - CH_W * (g + 1) +: CH_W]),
      .mul_en       (mul_en),
      .recip        (recip),
      .quotient     (lane_q[g])
    );
  end

  rsbb_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .load    (emit_load),
    .red     (lane_q[0]),
    .green   (lane_q[1]),
    .blue    (lane_q[2]),
    .done    (line_end_pos),
    .space   (space),
    .results (results)
  );

endmodule

`default_nettype wire

// ===== sv/rsbb_checker.sv =====
`default_nettype none

module rsbb_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      pix_valid,
  input logic                      pix_ready,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic [rsbb_pkg::CH_W-1:0] red,
  input logic [rsbb_pkg::CH_W-1:0] green,
  input logic [rsbb_pkg::CH_W-1:0] blue,
  input logic                      done
);
  import rsbb_pkg::*;

  // A stalled result request keeps its valid and its payload.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable({red, green, blue, done}))
    else $error("result changed while stalled");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // The cycle after an accepted pixel always goes to result bookkeeping.
  assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready |=> !pix_ready)
    else $error("pixel accepted on two consecutive cycles");

endmodule

bind running_sum_box_blur_line rsbb_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pixels.valid),
  .pix_ready (pixels.ready),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .red       (results.red_out),
  .green     (results.green_out),
  .blue      (results.blue_out),
  .done      (results.line_done)
);

`default_nettype wire
